// ===== rtl/core/rpm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpm_pkg
// Shared types, constants and helpers of the rainbow pseudo-color mapper.
// ----------------------------------------------------------------------------
package rpm_pkg;

	localparam int SAMPLE_WIDTH_DEF = 32;
	localparam int FIELD_WIDTH      = 32;
	localparam int COLOR_WIDTH      = 8;
	localparam int FRAC_BITS        = 16;
	localparam int SEG_FRAC_BITS    = 14;
	localparam int CFG_INDEX_WIDTH  = 2;

	localparam logic signed [FIELD_WIDTH-1:0] VALUE_MIN_RESET = 32'sd0;
	localparam logic signed [FIELD_WIDTH-1:0] VALUE_MAX_RESET = 32'sd65535;
	localparam logic [COLOR_WIDTH-1:0]        ALPHA_VALUE     = 8'd200;
	localparam logic [COLOR_WIDTH-1:0]        COLOR_FULL      = 8'd255;
	localparam logic [COLOR_WIDTH-1:0]        COLOR_NONE      = 8'd0;
	localparam logic [SEG_FRAC_BITS:0]        SEG_ONE         = 15'd16384;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_VALUE_MIN = 2'd0,
		REG_VALUE_MAX = 2'd1
	} cfg_reg_t;

	// how t16 is formed for an item
	typedef enum logic [1:0] {
		CLS_ZERO = 2'd0,
		CLS_FULL = 2'd1,
		CLS_DIV  = 2'd2
	} cls_t;

	typedef enum logic [1:0] {
		SEG_BLUE_CYAN   = 2'd0,
		SEG_CYAN_GREEN  = 2'd1,
		SEG_GREEN_YELLOW = 2'd2,
		SEG_YELLOW_RED  = 2'd3
	} seg_t;

	// floor(f * 255 / 16384), f in 0..16384
	function automatic logic [COLOR_WIDTH-1:0] ramp(input logic [SEG_FRAC_BITS:0] f);
		logic [22:0] p;
		p = {f, 8'b0} - {8'b0, f};
		return p[21:14];
	endfunction

endpackage

// ===== rtl/core/rpm_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpm_divider
// Pipelined restoring divider: q = floor(num * 2^FRAC_BITS / den) for num < den, one
// quotient bit per stage. Valid and item class travel alongside.
// ----------------------------------------------------------------------------
module rpm_divider import rpm_pkg::*; #(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_vld,
	input  cls_t                    in_cls,
	input  logic [SAMPLE_WIDTH-1:0] in_num,
	input  logic [SAMPLE_WIDTH-1:0] in_den,
	output logic                    out_vld,
	output cls_t                    out_cls,
	output logic [FRAC_BITS-1:0]    out_quo
);

	logic                    vld_s [0:FRAC_BITS];
	cls_t                    cls_s [0:FRAC_BITS];
	logic [SAMPLE_WIDTH-1:0] rem_s [0:FRAC_BITS];
	logic [SAMPLE_WIDTH-1:0] den_s [0:FRAC_BITS];
	logic [FRAC_BITS-1:0]    quo_s [0:FRAC_BITS];

	assign vld_s[0] = in_vld;
	assign cls_s[0] = in_cls;
	assign rem_s[0] = in_num;
	assign den_s[0] = in_den;
	assign quo_s[0] = '0;

	for (genvar i = 0; i < FRAC_BITS; i++) begin : g_stage
		logic [SAMPLE_WIDTH:0] shifted;
		logic [SAMPLE_WIDTH:0] diff;
		logic                  ge;

		assign shifted = {rem_s[i], 1'b0};
		assign ge      = shifted >= {1'b0, den_s[i]};
		assign diff    = shifted - {1'b0, den_s[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			cls_s[i+1] <= cls_s[i];
			den_s[i+1] <= den_s[i];
			rem_s[i+1] <= ge ? diff[SAMPLE_WIDTH-1:0] : shifted[SAMPLE_WIDTH-1:0];
			quo_s[i+1] <= {quo_s[i][FRAC_BITS-2:0], ge};
		end
	end

	assign out_vld = vld_s[FRAC_BITS];
	assign out_cls = cls_s[FRAC_BITS];
	assign out_quo = quo_s[FRAC_BITS];

endmodule

// ===== rtl/core/rainbow_pseudocolor_mapper_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rainbow_pseudocolor_mapper_top
// Maps each signed sample to RGBA on a blue-cyan-green-yellow-red ramp.
//
// channel | ports                                  | handshake
// --------+----------------------------------------+-------------------------
// input   | start, busy, sample                    | start && !busy
// result  | done, red, green, blue, alpha          | done strobe, one cycle
// config  | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid && cfg_ready
//
// One item per clock; busy is always low. From accept to done an item passes
// the input register, two setup stages, 16 divider stages (one quotient bit
// each) and two color stages. Reset clears all valid bits and loads the
// limit registers with their defaults. The receiver cannot stall.
// ----------------------------------------------------------------------------
module rainbow_pseudocolor_mapper_top import rpm_pkg::*; #(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [FIELD_WIDTH-1:0] sample,
	output logic                          done,
	output logic [COLOR_WIDTH-1:0]        red,
	output logic [COLOR_WIDTH-1:0]        green,
	output logic [COLOR_WIDTH-1:0]        blue,
	output logic [COLOR_WIDTH-1:0]        alpha,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
	input  logic [FIELD_WIDTH-1:0]        cfg_data
);

	logic signed [FIELD_WIDTH-1:0] value_min_q;
	logic signed [FIELD_WIDTH-1:0] value_max_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_min_q <= VALUE_MIN_RESET;
			value_max_q <= VALUE_MAX_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_VALUE_MIN: value_min_q <= $signed(cfg_data);
				REG_VALUE_MAX: value_max_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// stage 1: operands at working width
	logic                           vld_s1;
	logic signed [SAMPLE_WIDTH-1:0] smp_s1, min_s1, max_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		smp_s1 <= SAMPLE_WIDTH'(sample);
		min_s1 <= SAMPLE_WIDTH'(value_min_q);
		max_s1 <= SAMPLE_WIDTH'(value_max_q);
	end

	// stage 2: differences and range checks
	logic                    vld_s2, ok_s2;
	logic [SAMPLE_WIDTH-1:0] num_s2, den_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		ok_s2  <= (max_s1 > min_s1) && (smp_s1 > min_s1);
		num_s2 <= smp_s1 - min_s1;
		den_s2 <= max_s1 - min_s1;
	end

	// stage 3: saturation check
	logic                    vld_s3;
	cls_t                    cls_s3;
	logic [SAMPLE_WIDTH-1:0] num_s3, den_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		priority if (!ok_s2) begin
			cls_s3 <= CLS_ZERO;
		end else if (num_s2 >= den_s2) begin
			cls_s3 <= CLS_FULL;
		end else begin
			cls_s3 <= CLS_DIV;
		end
		num_s3 <= num_s2;
		den_s3 <= den_s2;
	end

	logic                 div_vld;
	cls_t                 div_cls;
	logic [FRAC_BITS-1:0] div_quo;

	rpm_divider #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (vld_s3),
		.in_cls (cls_s3),
		.in_num (num_s3),
		.in_den (den_s3),
		.out_vld(div_vld),
		.out_cls(div_cls),
		.out_quo(div_quo)
	);

	// color stage 1: segment and fractions
	logic                   vld_c1;
	seg_t                   seg_c1;
	logic [SEG_FRAC_BITS:0] fup_c1, fdn_c1;
	seg_t                   seg_d;
	logic [SEG_FRAC_BITS:0] f_d;

	always_comb begin
		unique case (div_cls)
			CLS_FULL: begin
				seg_d = SEG_YELLOW_RED;
				f_d   = SEG_ONE;
			end
			CLS_DIV: begin
				seg_d = seg_t'(div_quo[FRAC_BITS-1:SEG_FRAC_BITS]);
				f_d   = {1'b0, div_quo[SEG_FRAC_BITS-1:0]};
			end
			default: begin
				seg_d = SEG_BLUE_CYAN;
				f_d   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_c1 <= 1'b0;
		end else begin
			vld_c1 <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		seg_c1 <= seg_d;
		fup_c1 <= f_d;
		fdn_c1 <= SEG_ONE - f_d;
	end

	// color stage 2: channel bytes
	logic [COLOR_WIDTH-1:0] r_d, g_d, b_d, up_d, dn_d;

	assign up_d = ramp(fup_c1);
	assign dn_d = ramp(fdn_c1);

	always_comb begin
		unique case (seg_c1)
			SEG_BLUE_CYAN: begin
				r_d = COLOR_NONE; g_d = up_d;       b_d = COLOR_FULL;
			end
			SEG_CYAN_GREEN: begin
				r_d = COLOR_NONE; g_d = COLOR_FULL; b_d = dn_d;
			end
			SEG_GREEN_YELLOW: begin
				r_d = up_d;       g_d = COLOR_FULL; b_d = COLOR_NONE;
			end
			default: begin
				r_d = COLOR_FULL; g_d = dn_d;       b_d = COLOR_NONE;
			end
		endcase
	end

	logic                   vld_c2;
	logic [COLOR_WIDTH-1:0] red_c2, green_c2, blue_c2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_c2 <= 1'b0;
		end else begin
			vld_c2 <= vld_c1;
		end
	end

	always_ff @(posedge clk) begin
		red_c2   <= r_d;
		green_c2 <= g_d;
		blue_c2  <= b_d;
	end

	assign done  = vld_c2;
	assign red   = red_c2;
	assign green = green_c2;
	assign blue  = blue_c2;
	assign alpha = ALPHA_VALUE;

endmodule

// ===== tb/sv/rainbow_pseudocolor_mapper_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rainbow_pseudocolor_mapper_checker
// Follows the limit register writes, computes the rainbow color of every
// accepted sample and compares each done strobe with the oldest prediction.
// Reports pending predictions and the failure count to the testbench top.
// ----------------------------------------------------------------------------
module rainbow_pseudocolor_mapper_checker import rpm_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  logic signed [FIELD_WIDTH-1:0] sample,
	input  logic                          done,
	input  logic [COLOR_WIDTH-1:0]        red,
	input  logic [COLOR_WIDTH-1:0]        green,
	input  logic [COLOR_WIDTH-1:0]        blue,
	input  logic [COLOR_WIDTH-1:0]        alpha,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
	input  logic [FIELD_WIDTH-1:0]        cfg_data,
	output int                            pending,
	output int                            fail_count
);

	typedef struct packed {
		logic [COLOR_WIDTH-1:0] red;
		logic [COLOR_WIDTH-1:0] green;
		logic [COLOR_WIDTH-1:0] blue;
		logic [COLOR_WIDTH-1:0] alpha;
	} rgba_t;

	rgba_t                         colors_q[$];
	rgba_t                         want;
	logic signed [FIELD_WIDTH-1:0] lim_lo;
	logic signed [FIELD_WIDTH-1:0] lim_hi;
	int                            mismatches = 0;

	function automatic rgba_t rainbow_color(input logic signed [FIELD_WIDTH-1:0] v,
			input logic signed [FIELD_WIDTH-1:0] lo, input logic signed [FIELD_WIDTH-1:0] hi);
		longint                 span;
		longint                 offs;
		int                     t16;
		int                     frac;
		seg_t                   seg;
		logic [COLOR_WIDTH-1:0] rise;
		logic [COLOR_WIDTH-1:0] fall;
		rgba_t                  c;
		t16 = 0;
		span = longint'(hi) - longint'(lo);
		offs = longint'(v) - longint'(lo);
		if (span > 0 && offs > 0)
			t16 = (offs >= span) ? (1 << FRAC_BITS) : int'((offs << FRAC_BITS) / span);
		if ((t16 >> SEG_FRAC_BITS) > 3) begin
			seg = SEG_YELLOW_RED;
			frac = 1 << SEG_FRAC_BITS;
		end else begin
			seg = seg_t'(2'(t16 >> SEG_FRAC_BITS));
			frac = t16 % (1 << SEG_FRAC_BITS);
		end
		rise = COLOR_WIDTH'((frac * 255) >> SEG_FRAC_BITS);
		fall = COLOR_WIDTH'((((1 << SEG_FRAC_BITS) - frac) * 255) >> SEG_FRAC_BITS);
		c.alpha = ALPHA_VALUE;
		case (seg)
			SEG_BLUE_CYAN: begin
				c.red = COLOR_NONE;
				c.green = rise;
				c.blue = COLOR_FULL;
			end
			SEG_CYAN_GREEN: begin
				c.red = COLOR_NONE;
				c.green = COLOR_FULL;
				c.blue = fall;
			end
			SEG_GREEN_YELLOW: begin
				c.red = rise;
				c.green = COLOR_FULL;
				c.blue = COLOR_NONE;
			end
			default: begin
				c.red = COLOR_FULL;
				c.green = fall;
				c.blue = COLOR_NONE;
			end
		endcase
		return c;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_lo <= VALUE_MIN_RESET;
			lim_hi <= VALUE_MAX_RESET;
			colors_q.delete();
			pending <= 0;
		end else begin
			if (done) begin
				if (colors_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result r=%0d g=%0d b=%0d a=%0d",
							$time, red, green, blue, alpha);
				end else begin
					want = colors_q.pop_front();
					if (red !== want.red || green !== want.green || blue !== want.blue ||
							alpha !== want.alpha) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: rgba exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
								$time, want.red, want.green, want.blue, want.alpha,
								red, green, blue, alpha);
					end
				end
			end
			if (start && !busy)
				colors_q = {colors_q, rainbow_color(sample, lim_lo, lim_hi)};
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_VALUE_MIN)
					lim_lo <= cfg_data;
				else if (cfg_index == REG_VALUE_MAX)
					lim_hi <= cfg_data;
			end
			pending <= colors_q.size();
		end
	end

	// predictions still waiting at the end count as failures
	assign fail_count = mismatches + pending;

endmodule

// ===== tb/sv/rainbow_pseudocolor_mapper_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rainbow_pseudocolor_mapper_top_tb
// Drives samples and limit writes into the pseudo-color mapper: corner
// samples under fixed limits, then random samples under changing limits with
// varying sender gaps. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module rainbow_pseudocolor_mapper_top_tb;
	import rpm_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS    = 660;
	localparam int BLOCK_ITEMS    = 110;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_B = 2'd3;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	logic                          busy;
	logic signed [FIELD_WIDTH-1:0] sample = '0;
	logic                          done;
	logic [COLOR_WIDTH-1:0]        red;
	logic [COLOR_WIDTH-1:0]        green;
	logic [COLOR_WIDTH-1:0]        blue;
	logic [COLOR_WIDTH-1:0]        alpha;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [CFG_INDEX_WIDTH-1:0]    cfg_index = '0;
	logic [FIELD_WIDTH-1:0]        cfg_data = '0;
	int                            pending;
	int                            fail_count;
	int                            idle_cycles = 0;
	logic signed [FIELD_WIDTH-1:0] cur_lo;
	logic signed [FIELD_WIDTH-1:0] cur_hi;

	logic [FIELD_WIDTH-1:0] corner_pts [14] = '{
		32'h8000_0000, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd16383, 32'd16384, 32'd32767,
		32'd32768, 32'd49151, 32'd49152, 32'd65534, 32'd65535, 32'd65536, 32'h7FFF_FFFF
	};

	always #2 clk = ~clk;

	rainbow_pseudocolor_mapper_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sample(sample),
		.done(done), .red(red), .green(green), .blue(blue), .alpha(alpha),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	rainbow_pseudocolor_mapper_checker color_chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sample(sample),
		.done(done), .red(red), .green(green), .blue(blue), .alpha(alpha),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .pending(pending), .fail_count(fail_count)
	);

	task automatic push_sample(input logic [FIELD_WIDTH-1:0] v, input int gap_pct);
		while ($urandom_range(0, 99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		sample <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
			input logic [FIELD_WIDTH-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_limits(input logic [FIELD_WIDTH-1:0] lo, input logic [FIELD_WIDTH-1:0] hi);
		settle();
		write_reg(REG_VALUE_MIN, lo);
		write_reg(REG_VALUE_MAX, hi);
		cur_lo = lo;
		cur_hi = hi;
	endtask

	task automatic random_limits();
		logic [FIELD_WIDTH-1:0] lo;
		logic [FIELD_WIDTH-1:0] hi;
		lo = $urandom;
		case ($urandom_range(0, 5))
			0: hi = $urandom;
			1: hi = lo + $urandom_range(1, 1000);
			2: hi = lo + $urandom_range(1000, 1 << 20);
			3: begin
				lo = 32'h8000_0000;
				hi = 32'h7FFF_FFFF;
			end
			4: hi = lo;
			default: hi = lo - $urandom_range(1, 1 << 20);
		endcase
		set_limits(lo, hi);
		if ($urandom_range(0, 7) == 0)
			write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
	endtask

	// mostly around the range, the rest anywhere
	function automatic logic [FIELD_WIDTH-1:0] pick_sample();
		longint span;
		span = longint'(cur_hi) - longint'(cur_lo);
		if (span <= 0 || $urandom_range(0, 4) == 0)
			return $urandom;
		return FIELD_WIDTH'(longint'(cur_lo) - span / 8 +
			longint'({$urandom, $urandom} % (span + span / 4 + 1)));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("rainbow_pseudocolor_mapper_top_tb failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int gap;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset limits 0..65535: clamps and segment boundaries
		foreach (corner_pts[i])
			push_sample(corner_pts[i], 0);

		// widest range
		set_limits(32'h8000_0000, 32'h7FFF_FFFF);
		push_sample(32'h8000_0000, 0);
		push_sample(32'd0, 0);
		push_sample(32'h7FFF_FFFF, 0);
		push_sample(32'hFFFF_FFFF, 0);

		// unused register indexes leave the limits alone
		settle();
		write_reg(REG_SPARE_A, $urandom);
		write_reg(REG_SPARE_B, $urandom);
		push_sample(32'd0, 0);

		// empty and inverted ranges give blue
		set_limits(32'd100, 32'd100);
		push_sample(32'd99, 0);
		push_sample(32'd100, 0);
		push_sample(32'd101, 0);
		set_limits(32'h7FFF_FFFF, 32'h8000_0000);
		push_sample(32'd0, 0);
		push_sample(32'h7FFF_FFFF, 0);

		for (int ph = 0; ph < 3; ph++) begin
			gap = (ph == 0) ? 12 : (ph == 1) ? 64 : 0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % BLOCK_ITEMS == 0)
					random_limits();
				push_sample(pick_sample(), gap);
			end
		end

		settle();
		repeat (30) @(posedge clk);
		if (fail_count == 0)
			$display("rainbow_pseudocolor_mapper_top_tb passed");
		else
			$display("rainbow_pseudocolor_mapper_top_tb failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/rpm_pkg.sv
rtl/core/rpm_divider.sv
rtl/core/rainbow_pseudocolor_mapper_top.sv
tb/sv/rainbow_pseudocolor_mapper_checker.sv
tb/sv/rainbow_pseudocolor_mapper_top_tb.sv
